/* hdl/wphm_pkg.sv */
`default_nettype none
package wphm_pkg;

    // field widths
    localparam int VOLUME_BITS    = 40;
    localparam int TEMP_FRAC_BITS = 8;
    localparam int TEMP_W         = TEMP_FRAC_BITS + 9;
    localparam int ENERGY_W       = 48;
    localparam int HCAP_W         = 24;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;

    // physical limits and reset values
    localparam int TEMP_LIMIT_DEG = 300;
    localparam int MAXT_RESET_DEG = 50;
    localparam int HCAP_RESET     = 274399;
    localparam logic [TEMP_W-1:0] TEMP_MAX =
        TEMP_W'((TEMP_LIMIT_DEG << TEMP_FRAC_BITS) - 1);
    localparam logic [TEMP_W-1:0] MAXT_RESET = TEMP_W'(MAXT_RESET_DEG << TEMP_FRAC_BITS);

    // heat arithmetic widths
    localparam int ESHIFT     = TEMP_FRAC_BITS + 8;
    localparam int ES_W       = ENERGY_W + ESHIFT;
    localparam int ACC_BASE_W = VOLUME_BITS + TEMP_W + HCAP_W;
    localparam int WIDE_W     = ((ACC_BASE_W > ES_W) ? ACC_BASE_W : ES_W) + 1;

    // sliced multiplier: 32 x HCAP_W per cycle
    localparam int MUL_SW     = 32;
    localparam int VT_W       = VOLUME_BITS + TEMP_W;
    localparam int MUL_SLICES = (VT_W + MUL_SW - 1) / MUL_SW;
    localparam int MUL_AW     = MUL_SLICES * MUL_SW;
    localparam int PROD_W     = MUL_SW + HCAP_W;
    localparam int SLICE_W    = (MUL_SLICES > 1) ? $clog2(MUL_SLICES) : 1;
    localparam int CNT_MAX    = (TEMP_W > MUL_SLICES) ? TEMP_W : MUL_SLICES;
    localparam int CNT_W      = $clog2(CNT_MAX + 1);

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_MIX   = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_DRAIN = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DRAW  = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_EVAP  = KIND_W'(3);

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_ABOVE_MAX = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_NO_ENERGY = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] STATUS_NO_VOLUME = STATUS_W'(3);
    localparam logic [STATUS_W-1:0] STATUS_CLAMPED   = STATUS_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = CFG_IDX_W'(1);

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [VOLUME_BITS-1:0] in_volume;
        logic [TEMP_W-1:0]      in_temp;
        logic [ENERGY_W-1:0]    in_energy;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [VOLUME_BITS-1:0] volume_now;
        logic [TEMP_W-1:0]      temp_now;
        logic [VOLUME_BITS-1:0] out_volume;
        logic [TEMP_W-1:0]      out_temp;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_VT,
        S_MUL_IN,
        S_COPY,
        S_MUL_HC,
        S_CHECK,
        S_MUL_VC,
        S_LOAD_DIV,
        S_DIV_CHK,
        S_DIV_STEP,
        S_COMMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_COPY,
        OP_HEAT_NET,
        OP_LOAD_DIV,
        OP_DIV_CHK,
        OP_DIV_STEP,
        OP_COMMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        MA_VOL,
        MA_VIN,
        MA_NUM,
        MA_VNEW
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_TEMP,
        MB_TIN,
        MB_HCAP
    } mul_b_t;

    typedef struct packed {
        dp_op_t               op;
        logic                 mul_issue;
        logic                 mul_sub;
        mul_a_t               mul_a;
        mul_b_t               mul_b;
        logic [SLICE_W-1:0]   mul_slice;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              vin_zero;
        logic              heat_gt;
        logic              vol_ok;
        logic              out_free;
    } dp_status_t;

endpackage
`default_nettype wire

/* hdl/wphm_datapath.sv */
`default_nettype none
module wphm_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire wphm_pkg::in_item_t              s_data,
    output wire logic                            m_valid,
    input  wire logic                            m_ready,
    output wire wphm_pkg::out_item_t             m_data,
    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [wphm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wphm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire wphm_pkg::dp_cmd_t               cmd,
    output wphm_pkg::dp_status_t                 status
);
    import wphm_pkg::*;

    // parcel state and configuration
    logic [VOLUME_BITS-1:0] vol_reg;
    logic [TEMP_W-1:0]      temp_reg;
    logic [HCAP_W-1:0]      hcap_reg;
    logic [TEMP_W-1:0]      maxt_reg;

    // latched transaction
    logic [KIND_W-1:0]      kind_reg;
    logic [VOLUME_BITS-1:0] vin_reg;
    logic [TEMP_W-1:0]      tin_reg;
    logic [ENERGY_W-1:0]    e_reg;
    logic                   clamp_reg;
    logic                   neg_reg;
    logic                   e_fail_reg;
    logic                   v_fail_reg;

    // multiplier, accumulator and divider
    logic [PROD_W-1:0]      prod_reg;
    logic [SLICE_W-1:0]     prod_sh_reg;
    logic                   prod_vld_reg;
    logic                   prod_sub_reg;
    logic [WIDE_W-1:0]      acc_reg;
    logic [WIDE_W-1:0]      num_reg;
    logic [WIDE_W-1:0]      den_reg;
    logic [TEMP_W-1:0]      q_reg;
    logic                   ovf_reg;

    // result register
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    logic [VOLUME_BITS-1:0] vnew;
    logic [VOLUME_BITS:0]   vsum;
    logic [WIDE_W-1:0]      es_w;
    logic [WIDE_W-1:0]      acc_term;
    logic [MUL_AW-1:0]      mul_a_full;
    logic [MUL_SW-1:0]      mul_a_slice;
    logic [HCAP_W-1:0]      mul_b_val;
    logic [PROD_W-1:0]      prod_next;
    logic [TEMP_W-1:0]      q_sat;
    logic                   num_ge_den;
    logic                   latch_clamp;
    logic [TEMP_W-1:0]      latch_tin;
    out_item_t              res_next;

    // shared arithmetic terms
    assign vnew       = vol_reg - vin_reg;
    assign vsum       = {1'b0, vol_reg} + {1'b0, vin_reg};
    assign es_w       = WIDE_W'(e_reg) << ESHIFT;
    assign acc_term   = WIDE_W'(prod_reg) << (MUL_SW * prod_sh_reg);
    assign num_ge_den = num_reg >= den_reg;
    assign q_sat      = (ovf_reg || q_reg > TEMP_MAX) ? TEMP_MAX : q_reg;

    // input clamps applied at latch time
    assign latch_tin   = (s_data.in_temp > TEMP_MAX) ? TEMP_MAX : s_data.in_temp;
    assign latch_clamp = (s_data.kind == KIND_DRAIN || s_data.kind == KIND_DRAW)
                         && (s_data.in_volume > vol_reg);

    // multiplier operand selection
    always_comb begin
        unique case (cmd.mul_a)
            MA_VOL:  mul_a_full = MUL_AW'(vol_reg);
            MA_VIN:  mul_a_full = MUL_AW'(vin_reg);
            MA_NUM:  mul_a_full = MUL_AW'(num_reg[VT_W-1:0]);
            MA_VNEW: mul_a_full = MUL_AW'(vnew);
            default: mul_a_full = '0;
        endcase
        unique case (cmd.mul_b)
            MB_TEMP: mul_b_val = HCAP_W'(temp_reg);
            MB_TIN:  mul_b_val = HCAP_W'(tin_reg);
            MB_HCAP: mul_b_val = hcap_reg;
            default: mul_b_val = '0;
        endcase
    end

    assign mul_a_slice = mul_a_full[cmd.mul_slice * MUL_SW +: MUL_SW];
    assign prod_next   = PROD_W'(mul_a_slice) * PROD_W'(mul_b_val);

    // result of the committed operation
    always_comb begin
        res_next            = '0;
        res_next.status     = STATUS_OK;
        res_next.volume_now = vol_reg;
        res_next.temp_now   = temp_reg;
        unique case (kind_reg)
            KIND_MIX: begin
                if (vin_reg != '0) begin
                    res_next.temp_now = q_sat;
                    if (vsum[VOLUME_BITS]) begin
                        res_next.volume_now = '1;
                        res_next.status     = STATUS_CLAMPED;
                    end else begin
                        res_next.volume_now = vsum[VOLUME_BITS-1:0];
                    end
                end
            end
            KIND_DRAIN: begin
                res_next.volume_now = vnew;
                res_next.out_volume = vin_reg;
                res_next.out_temp   = temp_reg;
                res_next.status     = clamp_reg ? STATUS_CLAMPED : STATUS_OK;
            end
            KIND_DRAW: begin
                res_next.volume_now = vnew;
                res_next.temp_now   = (vnew == '0) ? '0 : q_sat;
                res_next.status     = (clamp_reg || neg_reg) ? STATUS_CLAMPED : STATUS_OK;
            end
            KIND_EVAP: begin
                if (e_fail_reg) begin
                    res_next.status = STATUS_NO_ENERGY;
                end else if (v_fail_reg) begin
                    res_next.status = STATUS_NO_VOLUME;
                end else begin
                    res_next.volume_now = vnew;
                    res_next.temp_now   = q_sat;
                    res_next.status     = (q_sat > maxt_reg) ? STATUS_ABOVE_MAX : STATUS_OK;
                end
            end
            default: res_next = '0;
        endcase
    end

    // control state: parcel, configuration, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg      <= '0;
            temp_reg     <= '0;
            hcap_reg     <= HCAP_W'(HCAP_RESET);
            maxt_reg     <= MAXT_RESET;
            m_valid_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_issue;
            if (cmd.op == OP_COMMIT) begin
                vol_reg     <= res_next.volume_now;
                temp_reg    <= res_next.temp_now;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_HEAT_CAP: hcap_reg <= cfg_data[HCAP_W-1:0];
                    REG_MAX_TEMP: maxt_reg <= cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // multiplier pipeline register
    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        prod_sh_reg  <= cmd.mul_slice;
        prod_sub_reg <= cmd.mul_sub;
    end

    // accumulator: cleared by some ops, otherwise adds or subtracts slice products
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LATCH || cmd.op == OP_COPY || cmd.op == OP_HEAT_NET) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= prod_sub_reg ? (acc_reg - acc_term) : (acc_reg + acc_term);
        end
    end

    // transaction latch, divider and result register
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_NONE: ;
            OP_LATCH: begin
                kind_reg  <= s_data.kind;
                vin_reg   <= latch_clamp ? vol_reg : s_data.in_volume;
                clamp_reg <= latch_clamp;
                tin_reg   <= latch_tin;
                e_reg     <= s_data.in_energy;
                neg_reg   <= 1'b0;
            end
            OP_COPY: num_reg <= acc_reg;
            OP_HEAT_NET: begin
                num_reg    <= acc_reg - es_w;
                e_fail_reg <= !(acc_reg > es_w);
                v_fail_reg <= vin_reg >= vol_reg;
            end
            OP_LOAD_DIV: begin
                unique case (kind_reg)
                    KIND_MIX: begin
                        num_reg <= acc_reg;
                        den_reg <= WIDE_W'(vsum);
                    end
                    KIND_DRAW: begin
                        neg_reg <= acc_reg[WIDE_W-1];
                        num_reg <= acc_reg[WIDE_W-1] ? '0 : acc_reg;
                        den_reg <= WIDE_W'(vnew);
                    end
                    KIND_EVAP: den_reg <= acc_reg;
                    default:   den_reg <= '0;
                endcase
            end
            OP_DIV_CHK: begin
                ovf_reg <= num_reg >= (den_reg << TEMP_W);
                den_reg <= den_reg << (TEMP_W - 1);
                q_reg   <= '0;
            end
            OP_DIV_STEP: begin
                if (num_ge_den) begin
                    num_reg <= num_reg - den_reg;
                end
                q_reg   <= {q_reg[TEMP_W-2:0], num_ge_den};
                den_reg <= den_reg >> 1;
            end
            OP_COMMIT: m_data_reg <= res_next;
            default: ;
        endcase
    end

    // status to the controller
    assign status.kind     = kind_reg;
    assign status.vin_zero = (vin_reg == '0);
    assign status.heat_gt  = acc_reg > es_w;
    assign status.vol_ok   = vin_reg < vol_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

/* hdl/wphm_ctrl.sv */
`default_nettype none
module wphm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire wphm_pkg::dp_status_t status,
    output wphm_pkg::dp_cmd_t         cmd
);
    import wphm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             mul_done;
    logic             div_done;

    assign mul_done = (cnt_reg == CNT_W'(MUL_SLICES));
    assign div_done = (cnt_reg == CNT_W'(TEMP_W - 1));

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cnt_next = '0;
                unique case (status.kind)
                    KIND_MIX:   state_next = status.vin_zero ? S_COMMIT : S_MUL_VT;
                    KIND_DRAIN: state_next = S_COMMIT;
                    KIND_DRAW:  state_next = S_MUL_VT;
                    KIND_EVAP:  state_next = S_MUL_VT;
                    default:    state_next = S_COMMIT;
                endcase
            end
            S_MUL_VT, S_MUL_IN, S_MUL_HC, S_MUL_VC: begin
                if (mul_done) begin
                    cnt_next = '0;
                    unique case (state_reg)
                        S_MUL_VT: state_next = (status.kind == KIND_EVAP) ? S_COPY : S_MUL_IN;
                        S_MUL_HC: state_next = S_CHECK;
                        default:  state_next = S_LOAD_DIV;
                    endcase
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COPY:     state_next = S_MUL_HC;
            S_CHECK: begin
                state_next = (status.heat_gt && status.vol_ok) ? S_MUL_VC : S_COMMIT;
            end
            S_LOAD_DIV: state_next = S_DIV_CHK;
            S_DIV_CHK: begin
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (div_done) begin
                    cnt_next   = '0;
                    state_next = S_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COMMIT: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.mul_a     = MA_VOL;
        cmd.mul_b     = MB_TEMP;
        cmd.mul_slice = cnt_reg[SLICE_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LATCH;
                end
            end
            S_DISPATCH: ;
            S_MUL_VT: begin
                cmd.mul_issue = !mul_done;
                cmd.mul_a     = MA_VOL;
                cmd.mul_b     = MB_TEMP;
            end
            S_MUL_IN: begin
                cmd.mul_issue = !mul_done;
                cmd.mul_sub   = (status.kind == KIND_DRAW);
                cmd.mul_a     = MA_VIN;
                cmd.mul_b     = MB_TIN;
            end
            S_COPY:   cmd.op = OP_COPY;
            S_MUL_HC: begin
                cmd.mul_issue = !mul_done;
                cmd.mul_a     = MA_NUM;
                cmd.mul_b     = MB_HCAP;
            end
            S_CHECK:  cmd.op = OP_HEAT_NET;
            S_MUL_VC: begin
                cmd.mul_issue = !mul_done;
                cmd.mul_a     = MA_VNEW;
                cmd.mul_b     = MB_HCAP;
            end
            S_LOAD_DIV: cmd.op = OP_LOAD_DIV;
            S_DIV_CHK:  cmd.op = OP_DIV_CHK;
            S_DIV_STEP: cmd.op = OP_DIV_STEP;
            S_COMMIT: begin
                if (status.out_free) begin
                    cmd.op = OP_COMMIT;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/water_parcel_heat_mixer.sv */
// Water parcel heat mixer: holds one parcel (volume, temperature) and applies
// one operation per input transaction: mix in, discharge by volume, discharge
// of a given parcel, or evaporation.
// Input channel s_valid/s_ready/s_data carries one operation; each accepted
// transaction gives exactly one result on m_valid/m_ready/m_data.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// heat_capacity (index 0) and max_temperature (index 1); cfg_ready is always
// high. Write configuration only while no transaction is in flight.
// Discharge by volume and a zero inflow go straight from dispatch to commit;
// mix and discharge of a given parcel form the heat products and divide, and
// evaporation also checks net heat and volume, committing at once on a reject.
// After the result is loaded the engine returns to idle and only then takes
// the next transaction. The work is done by the 17-step restoring divider for
// the new temperature and the 32 x 24 multiplier that forms each heat product
// in two slices followed by a drain step.
// Reset (aresetn low, synchronous) clears the parcel to zero volume and
// temperature and loads the default configuration.
// A stalled receiver holds the result in the output register; the engine
// finishes the next transaction and waits until the register is free.
`default_nettype none
module water_parcel_heat_mixer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output wire logic                            s_ready,
    input  wire wphm_pkg::in_item_t              s_data,
    output wire logic                            m_valid,
    input  wire logic                            m_ready,
    output wire wphm_pkg::out_item_t             m_data,
    input  wire logic                            cfg_valid,
    output wire logic                            cfg_ready,
    input  wire logic [wphm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wphm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wphm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    wphm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // heat arithmetic and parcel state
    wphm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire
